FILE: hdl/assert_macros.svh
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/lpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lpf_pkg;
	localparam int MAX_LEN = 512;
	localparam int MAX_OUT = 64;
	localparam int AW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int CW = LW + 1;
	localparam int KW = 7;
	localparam int PL_W = 10;
	localparam int SP_W = 9;
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW = $clog2(FQ_DEPTH);

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic [PL_W-1:0] pal_length;
		logic [SP_W-1:0] start_pos;
		logic            last_of_run;
		logic            word_truncated;
		logic            list_overflow;
	} out_word_t;

	typedef struct packed {
		logic     valid;
		in_word_t word;
	} link_t;
endpackage
`default_nettype wire

FILE: hdl/lpf_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lpf_front import lpf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_word_t item,
	output link_t         link,
	input  wire logic     take
);
	in_word_t          q_q [FQ_DEPTH];
	logic [FQ_AW-1:0]  wp_q, rp_q;
	logic [FQ_AW:0]    cnt_q;
	logic              do_push, do_pop;

	assign full = (cnt_q == (FQ_AW+1)'(FQ_DEPTH));
	assign do_push = push && !full;
	assign do_pop = take && (cnt_q != '0);
	assign link.valid = (cnt_q != '0);
	assign link.word = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wp_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (FQ_AW+1)'(do_push) - (FQ_AW+1)'(do_pop);
		end
	end
endmodule
`default_nettype wire

FILE: hdl/lpf_back.sv
`timescale 1ns / 1ps
`default_nettype none
module lpf_back import lpf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire link_t link,
	output logic       take,
	output logic       empty,
	input  wire logic  pop,
	output out_word_t  result
);
	typedef enum logic [3:0] {
		S_LOAD, S_CINIT, S_CCHK, S_CCMP, S_CFIN, S_PSTART,
		S_PINIT, S_PCHK, S_PCMP, S_PHIT, S_ZERO, S_END
	} state_t;

	state_t          st_q;
	logic [7:0]      mem [MAX_LEN];
	logic [7:0]      rda_q, rdb_q;
	logic [LW-1:0]   wlen_q, lo_q, hi_q, best_q, s_q, a_q, b_q;
	logic [CW-1:0]   c_q;
	logic [KW-1:0]   total_q, k_q;
	logic            trunc_q, pass_q;
	logic [AW-1:0]   ra, rb;
	logic [LW-1:0]   len, n_next;
	logic [LW:0]     span_end;
	logic [KW-1:0]   lim;
	logic            room, opush;
	out_word_t       onew;
	out_word_t       oq_q [2];
	logic            owp_q, orp_q;
	logic [1:0]      ocnt_q;
	logic [LW+PL_W-1:0] best_ext;
	logic [LW+SP_W-1:0] s_ext;

	assign take = (st_q == S_LOAD);
	assign len = hi_q - lo_q;
	assign n_next = (wlen_q < LW'(MAX_LEN)) ? wlen_q + 1'b1 : wlen_q;
	assign span_end = {1'b0, s_q} + {1'b0, best_q};
	assign lim = (total_q > KW'(MAX_OUT)) ? KW'(MAX_OUT) : total_q;
	assign room = (ocnt_q != 2'd2);
	assign best_ext = {{PL_W{1'b0}}, best_q};
	assign s_ext = {{SP_W{1'b0}}, s_q};

	always_comb begin
		logic [LW-1:0] lm1;
		lm1 = lo_q - 1'b1;
		if (st_q == S_PCHK) begin
			ra = a_q[AW-1:0];
			rb = b_q[AW-1:0];
		end else begin
			ra = lm1[AW-1:0];
			rb = hi_q[AW-1:0];
		end
	end

	always_comb begin
		opush = 1'b0;
		onew.pal_length = best_ext[PL_W-1:0];
		onew.start_pos = s_ext[SP_W-1:0];
		onew.last_of_run = ((k_q + 1'b1) == lim);
		onew.word_truncated = trunc_q;
		onew.list_overflow = (total_q > KW'(MAX_OUT));
		if (st_q == S_ZERO) begin
			opush = room;
			onew.pal_length = '0;
			onew.start_pos = '0;
			onew.last_of_run = 1'b1;
			onew.list_overflow = 1'b0;
		end else if (st_q == S_PHIT && pass_q) begin
			opush = room;
		end
	end

	always_ff @(posedge clk) begin
		if (take && link.valid && wlen_q < LW'(MAX_LEN)) begin
			mem[wlen_q[AW-1:0]] <= link.word.char_code;
		end
		rda_q <= mem[ra];
		rdb_q <= mem[rb];
		if (opush) begin
			oq_q[owp_q] <= onew;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LOAD;
			wlen_q <= '0;
			trunc_q <= 1'b0;
			c_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			best_q <= '0;
			s_q <= '0;
			a_q <= '0;
			b_q <= '0;
			total_q <= '0;
			k_q <= '0;
			pass_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_LOAD: begin
					if (link.valid) begin
						wlen_q <= n_next;
						if (wlen_q >= LW'(MAX_LEN)) begin
							trunc_q <= 1'b1;
						end
						if (link.word.is_last) begin
							best_q <= '0;
							c_q <= '0;
							st_q <= (n_next < LW'(2)) ? S_ZERO : S_CINIT;
						end
					end
				end
				S_CINIT: begin
					lo_q <= c_q[CW-1:1] + 1'b1;
					hi_q <= c_q[CW-1:1] + LW'(c_q[0]);
					st_q <= S_CCHK;
				end
				S_CCHK: begin
					st_q <= (lo_q != '0 && hi_q < wlen_q) ? S_CCMP : S_CFIN;
				end
				S_CCMP: begin
					if (rda_q == rdb_q) begin
						lo_q <= lo_q - 1'b1;
						hi_q <= hi_q + 1'b1;
						st_q <= S_CCHK;
					end else begin
						st_q <= S_CFIN;
					end
				end
				S_CFIN: begin
					if (len > best_q) begin
						best_q <= len;
					end
					if ((c_q + 1'b1) == ({1'b0, wlen_q} << 1) - 1'b1) begin
						st_q <= S_PSTART;
					end else begin
						c_q <= c_q + 1'b1;
						st_q <= S_CINIT;
					end
				end
				S_PSTART: begin
					pass_q <= 1'b0;
					s_q <= '0;
					total_q <= '0;
					k_q <= '0;
					if (best_q < LW'(2)) begin
						best_q <= '0;
						st_q <= S_ZERO;
					end else begin
						st_q <= S_PINIT;
					end
				end
				S_PINIT: begin
					if (span_end > {1'b0, wlen_q}) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
							s_q <= '0;
						end else begin
							st_q <= S_END;
						end
					end else begin
						a_q <= s_q;
						b_q <= s_q + best_q - 1'b1;
						st_q <= S_PCHK;
					end
				end
				S_PCHK: begin
					st_q <= (a_q < b_q) ? S_PCMP : S_PHIT;
				end
				S_PCMP: begin
					if (rda_q == rdb_q) begin
						a_q <= a_q + 1'b1;
						b_q <= b_q - 1'b1;
						st_q <= S_PCHK;
					end else begin
						s_q <= s_q + 1'b1;
						st_q <= S_PINIT;
					end
				end
				S_PHIT: begin
					if (!pass_q) begin
						if (total_q <= KW'(MAX_OUT)) begin
							total_q <= total_q + 1'b1;
						end
						s_q <= s_q + 1'b1;
						st_q <= S_PINIT;
					end else if (room) begin
						k_q <= k_q + 1'b1;
						s_q <= s_q + 1'b1;
						st_q <= onew.last_of_run ? S_END : S_PINIT;
					end
				end
				S_ZERO: begin
					if (room) begin
						st_q <= S_END;
					end
				end
				S_END: begin
					wlen_q <= '0;
					trunc_q <= 1'b0;
					st_q <= S_LOAD;
				end
				default: st_q <= S_LOAD;
			endcase
		end
	end

	assign empty = (ocnt_q == 2'd0);
	assign result = oq_q[orp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q <= 1'b0;
			orp_q <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (opush) begin
				owp_q <= ~owp_q;
			end
			if (pop && !empty) begin
				orp_q <= ~orp_q;
			end
			ocnt_q <= ocnt_q + 2'(opush) - 2'(pop && !empty);
		end
	end
endmodule
`default_nettype wire

FILE: hdl/longest_palindrome_finder.sv
// channel  | handshake          | payload
// item     | push / full        | in_word_t  (char_code, is_last)
// result   | pop / empty        | out_word_t (length, start, flags)
// Bytes load at one per cycle, while the front is not full and the
// back end is loading, into a 4-entry front queue and the buffer. The
// search after the last byte expands around each of 2n-1 centers, then
// scans starts twice (count, emit). Front fills during the search.
// Reset clears all control; buffer contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module longest_palindrome_finder import lpf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_word_t item,
	output logic          empty,
	input  wire logic     pop,
	output out_word_t     result
);
	link_t link;
	logic  take;

	lpf_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.link(link), .take(take)
	);

	lpf_back u_back (
		.clk(clk), .arst_n(arst_n), .link(link), .take(take),
		.empty(empty), .pop(pop), .result(result)
	);

	`ASSERT_IMPL(a_zero_last, clk, arst_n, !empty && result.pal_length == '0, result.last_of_run, "zero-length result not last")
	`ASSERT_IMPL(a_ovf_len, clk, arst_n, !empty && result.list_overflow, result.pal_length != '0, "overflow on empty result")
	`ASSERT_NEXT(a_full_hold, clk, arst_n, full && !take, full, "front queue lost entries")
endmodule
`default_nettype wire
